>>> hw/rtl/warp_point_projection_top_assert.svh
// ----------------------------------------------------------------------------
// Warp point projection assertion macros
// Concurrent check macros used by the projection top level; clk and rst_n must be
// in scope where a macro is used.
// ----------------------------------------------------------------------------
`ifndef WARP_POINT_PROJECTION_TOP_ASSERT_SVH
`define WARP_POINT_PROJECTION_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("warp point projection: implication check failed");

// next-cycle implication
`define WPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("warp point projection: next-cycle check failed");

`else

`define WPP_ASSERT_IMP(lbl, ante, cons)
`define WPP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/warp_pp_pkg.sv
// ----------------------------------------------------------------------------
// Warp point projection package
// Shared widths, codes and bundle types of the point projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package warp_pp_pkg;

    localparam int PointW   = 16;
    localparam int CoefW    = 32;
    localparam int CoefXW   = CoefW + 1;   // coefficient with room for negation
    localparam int HomW     = 19;          // 4*x+1 range
    localparam int ProjW    = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int SumW     = 56;          // pre-rounding sums, homography terms
    localparam int RndW     = 64;          // rounded coordinate before clamp
    localparam int QuotBits = 34;          // quotient bits kept before overflow

    localparam logic signed [ProjW-1:0] ProjMax = 32'sh7FFF_FFFF;
    localparam logic signed [ProjW-1:0] ProjMin = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODEL_TRANSLATION = 2'd0,
        MODEL_ROTZOOM     = 2'd1,
        MODEL_AFFINE      = 2'd2,
        MODEL_HOMOGRAPHY  = 2'd3
    } model_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODEL_TYPE  = 3'd0,
        CFG_SUBSAMPLE_X = 3'd1,
        CFG_SUBSAMPLE_Y = 3'd2,
        CFG_COEF_A      = 3'd3,
        CFG_COEF_B      = 3'd4,
        CFG_COEF_C      = 3'd5,
        CFG_COEF_D      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        model_t                 model;
        logic                   sub_x;
        logic                   sub_y;
        logic [7:0][CoefW-1:0]  coef;
    } cfg_t;

    // homography side flags that travel with the division
    typedef struct packed {
        logic zero_den;
        logic neg_x;
        logic neg_y;
        logic nx_pos;
        logic nx_neg;
        logic ny_pos;
        logic ny_neg;
    } flags_t;

    typedef struct packed {
        flags_t            flags;
        logic [RndW-1:0]   rnd_x;   // non-homography result, signed
        logic [RndW-1:0]   rnd_y;
    } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/warp_pp_front.sv
// ----------------------------------------------------------------------------
// Warp point projection front end
// Five register stages: input, products, sums, rounding or numerator prep,
// and magnitudes for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_pp_front #(
    parameter int MODEL_PREC_BITS = 8,
    parameter int PIXEL_PREC_BITS = 6,
    parameter int HOMO_PREC_BITS  = 12,
    parameter int NUM_W           = 63
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  warp_pp_pkg::cfg_t                    cfg,
    input  logic                                 in_valid,
    input  logic signed [warp_pp_pkg::PointW-1:0] point_x,
    input  logic signed [warp_pp_pkg::PointW-1:0] point_y,
    output logic                                 out_valid,
    output logic [NUM_W-1:0]                     nabs_x,
    output logic [NUM_W-1:0]                     nabs_y,
    output logic [warp_pp_pkg::SumW-1:0]         den,
    output warp_pp_pkg::side_t                   side
);

    localparam int CW   = warp_pp_pkg::CoefXW;
    localparam int HW   = warp_pp_pkg::HomW;
    localparam int PW   = CW + HW;
    localparam int SW   = warp_pp_pkg::SumW;
    localparam int RW   = warp_pp_pkg::RndW;
    localparam int TW   = CW + 2;
    localparam int Diff = MODEL_PREC_BITS - PIXEL_PREC_BITS;
    localparam int Hs   = PIXEL_PREC_BITS + HOMO_PREC_BITS - MODEL_PREC_BITS;
    localparam int HsPos = (Hs > 0) ? Hs : 0;
    localparam int HsNeg = (Hs < 0) ? -Hs : 0;

    // round half away from zero by 2^n, or scale up when n is not positive
    function automatic logic signed [RW-1:0] round_shift(input logic signed [SW-1:0] v,
                                                         input int n);
        logic signed [RW-1:0] w;
        logic signed [RW-1:0] h;
        logic signed [RW-1:0] one_w;
        w     = RW'(v);
        one_w = $signed(RW'(1));
        h     = one_w <<< ((n > 0) ? (n - 1) : 0);
        if (n <= 0)
            return w <<< ((n < 0) ? -n : 0);
        if (w < 0)
            return (w + h - one_w) >>> n;
        return (w + h) >>> n;
    endfunction

    // configuration view (the user must keep it static while items are in flight; the block does not enforce this)
    logic                 homo, trans, rotzoom;
    logic signed [CW-1:0] c [8];
    logic signed [CW-1:0] ax, bx, ay, by;

    always_comb
    begin
        homo    = (cfg.model == warp_pp_pkg::MODEL_HOMOGRAPHY);
        trans   = (cfg.model == warp_pp_pkg::MODEL_TRANSLATION);
        rotzoom = (cfg.model == warp_pp_pkg::MODEL_ROTZOOM);
        for (int i = 0; i < 8; i++)
        begin
            c[i] = CW'($signed(cfg.coef[i]));
        end
        ax = homo ? c[0] : c[2];
        bx = homo ? c[1] : c[3];
        ay = homo ? c[3] : (rotzoom ? -c[3] : c[4]);
        by = homo ? c[4] : (rotzoom ? c[2] : c[5]);
    end

    // ---------------- stage 1: input register
    logic                                 v1_reg;
    logic signed [warp_pp_pkg::PointW-1:0] x1_reg, y1_reg;

    // ---------------- stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pax_reg, pbx_reg, pay_reg, pby_reg, pzx_reg, pzy_reg;
    logic signed [PW-1:0] pax_next, pbx_next, pay_next, pby_next, pzx_next, pzy_next;
    logic signed [warp_pp_pkg::PointW-1:0] x2_reg, y2_reg;

    logic signed [HW-1:0] xe, ye, hx, hy, u, w;

    always_comb
    begin
        xe = HW'(x1_reg);
        ye = HW'(y1_reg);
        hx = cfg.sub_x ? ((xe <<< 2) | HW'(1)) : (xe <<< 1);
        hy = cfg.sub_y ? ((ye <<< 2) | HW'(1)) : (ye <<< 1);
        u  = homo ? hx : xe;
        w  = homo ? hy : ye;
        pax_next = ax * u;
        pbx_next = bx * w;
        pay_next = ay * u;
        pby_next = by * w;
        pzx_next = c[6] * u;
        pzy_next = c[7] * w;
    end

    // ---------------- stage 3: sums
    logic                 v3_reg;
    logic signed [SW-1:0] vx3_reg, vy3_reg, z3_reg;
    logic signed [SW-1:0] vx_next, vy_next, z_next;
    logic signed [SW-1:0] sumx, sumy;
    logic signed [TW-1:0] tx, ty, htx, hty;

    always_comb
    begin
        sumx = SW'(pax_reg) + SW'(pbx_reg);
        sumy = SW'(pay_reg) + SW'(pby_reg);
        tx   = TW'(ax) + TW'(bx) - ($signed(TW'(1)) <<< MODEL_PREC_BITS);
        ty   = TW'(ay) + TW'(by) - ($signed(TW'(1)) <<< MODEL_PREC_BITS);
        // truncating halves
        htx  = (tx + $signed(TW'(tx[TW-1]))) >>> 1;
        hty  = (ty + $signed(TW'(ty[TW-1]))) >>> 1;
        z_next = SW'(pzx_reg) + SW'(pzy_reg)
                 + ($signed(SW'(1)) <<< (HOMO_PREC_BITS + 1));
        if (homo)
        begin
            vx_next = sumx + (SW'(c[2]) <<< 1);
            vy_next = sumy + (SW'(c[5]) <<< 1);
        end
        else if (trans)
        begin
            vx_next = (SW'(x2_reg) <<< (MODEL_PREC_BITS + (cfg.sub_x ? 1 : 0))) + SW'(c[0]);
            vy_next = (SW'(y2_reg) <<< (MODEL_PREC_BITS + (cfg.sub_y ? 1 : 0))) + SW'(c[1]);
        end
        else
        begin
            vx_next = cfg.sub_x ? ((sumx <<< 1) + SW'(c[0]) + SW'(htx)) : (sumx + SW'(c[0]));
            vy_next = cfg.sub_y ? ((sumy <<< 1) + SW'(c[1]) + SW'(hty)) : (sumy + SW'(c[1]));
        end
    end

    // ---------------- stage 4: rounding, homography numerator with half denominator
    logic                    v4_reg;
    logic signed [RW-1:0]    rx4_reg, ry4_reg, rx_next, ry_next;
    logic signed [NUM_W-1:0] nx4_reg, ny4_reg, nx_next, ny_next, nshx, nshy;
    logic signed [SW-1:0]    z4_reg, halfz;
    logic                    nxp4_reg, nxn4_reg, nyp4_reg, nyn4_reg;

    always_comb
    begin
        if (trans)
        begin
            rx_next = cfg.sub_x ? round_shift(vx3_reg, PIXEL_PREC_BITS + 1)
                                : round_shift(vx3_reg, PIXEL_PREC_BITS);
            ry_next = cfg.sub_y ? round_shift(vy3_reg, PIXEL_PREC_BITS + 1)
                                : round_shift(vy3_reg, PIXEL_PREC_BITS);
        end
        else
        begin
            rx_next = cfg.sub_x ? round_shift(vx3_reg, Diff + 1) : round_shift(vx3_reg, Diff);
            ry_next = cfg.sub_y ? round_shift(vy3_reg, Diff + 1) : round_shift(vy3_reg, Diff);
        end
        nshx  = (NUM_W'(vx3_reg) <<< HsPos) >>> HsNeg;
        nshy  = (NUM_W'(vy3_reg) <<< HsPos) >>> HsNeg;
        halfz = (z3_reg + $signed(SW'(z3_reg[SW-1]))) >>> 1;
        nx_next = (nshx <= 0) ? (nshx - NUM_W'(halfz)) : (nshx + NUM_W'(halfz));
        ny_next = (nshy <= 0) ? (nshy - NUM_W'(halfz)) : (nshy + NUM_W'(halfz));
    end

    // ---------------- stage 5: magnitudes and signs
    warp_pp_pkg::side_t side_next;
    logic [NUM_W-1:0]   nabsx_next, nabsy_next;
    logic [SW-1:0]      den_next;

    always_comb
    begin
        nabsx_next = nx4_reg[NUM_W-1] ? NUM_W'(-nx4_reg) : NUM_W'(nx4_reg);
        nabsy_next = ny4_reg[NUM_W-1] ? NUM_W'(-ny4_reg) : NUM_W'(ny4_reg);
        den_next   = z4_reg[SW-1] ? SW'(-z4_reg) : SW'(z4_reg);
        side_next.flags.zero_den = (z4_reg == '0);
        side_next.flags.neg_x    = nx4_reg[NUM_W-1] ^ z4_reg[SW-1];
        side_next.flags.neg_y    = ny4_reg[NUM_W-1] ^ z4_reg[SW-1];
        side_next.flags.nx_pos   = nxp4_reg;
        side_next.flags.nx_neg   = nxn4_reg;
        side_next.flags.ny_pos   = nyp4_reg;
        side_next.flags.ny_neg   = nyn4_reg;
        side_next.rnd_x          = rx4_reg;
        side_next.rnd_y          = ry4_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_valid <= v4_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= point_x;
            y1_reg   <= point_y;
            pax_reg  <= pax_next;
            pbx_reg  <= pbx_next;
            pay_reg  <= pay_next;
            pby_reg  <= pby_next;
            pzx_reg  <= pzx_next;
            pzy_reg  <= pzy_next;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            vx3_reg  <= vx_next;
            vy3_reg  <= vy_next;
            z3_reg   <= z_next;
            rx4_reg  <= rx_next;
            ry4_reg  <= ry_next;
            nx4_reg  <= nx_next;
            ny4_reg  <= ny_next;
            z4_reg   <= z3_reg;
            nxp4_reg <= (vx3_reg > 0);
            nxn4_reg <= (vx3_reg < 0);
            nyp4_reg <= (vy3_reg > 0);
            nyn4_reg <= (vy3_reg < 0);
            nabs_x   <= nabsx_next;
            nabs_y   <= nabsy_next;
            den      <= den_next;
            side     <= side_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/warp_pp_div.sv
// ----------------------------------------------------------------------------
// Warp point projection divider
// Pipelined restoring division of two magnitudes by one shared divisor:
// an overflow stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_pp_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 56,
    parameter int QB     = 34,
    parameter int SIDE_W = 135
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  nabs_x,
    input  logic [NUM_W-1:0]  nabs_y,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QB-1:0]     quo_x,
    output logic [QB-1:0]     quo_y,
    output logic              ovf_x,
    output logic              ovf_y,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RW = NUM_W + QB;

    logic              v_reg  [0:QB];
    logic [RW-1:0]     rx_reg [0:QB];
    logic [RW-1:0]     ry_reg [0:QB];
    logic [QB-1:0]     qx_reg [0:QB];
    logic [QB-1:0]     qy_reg [0:QB];
    logic              ox_reg [0:QB];
    logic              oy_reg [0:QB];
    logic [DEN_W-1:0]  d_reg  [0:QB];
    logic [SIDE_W-1:0] s_reg  [0:QB];

    // entry stage: quotient too large for QB bits
    logic [RW-1:0] dtop;

    always_comb
    begin
        dtop = RW'(den) << QB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= RW'(nabs_x);
            ry_reg[0] <= RW'(nabs_y);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            ox_reg[0] <= (RW'(nabs_x) >= dtop);
            oy_reg[0] <= (RW'(nabs_y) >= dtop);
            d_reg[0]  <= den;
            s_reg[0]  <= side_in;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [RW-1:0] dsh;
        logic          gex, gey;

        always_comb
        begin
            dsh = RW'(d_reg[j-1]) << (QB - j);
            gex = (rx_reg[j-1] >= dsh);
            gey = (ry_reg[j-1] >= dsh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[j] <= gex ? (rx_reg[j-1] - dsh) : rx_reg[j-1];
                ry_reg[j] <= gey ? (ry_reg[j-1] - dsh) : ry_reg[j-1];
                qx_reg[j] <= {qx_reg[j-1][QB-2:0], gex};
                qy_reg[j] <= {qy_reg[j-1][QB-2:0], gey};
                ox_reg[j] <= ox_reg[j-1];
                oy_reg[j] <= oy_reg[j-1];
                d_reg[j]  <= d_reg[j-1];
                s_reg[j]  <= s_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quo_x     = qx_reg[QB];
    assign quo_y     = qy_reg[QB];
    assign ovf_x     = ox_reg[QB];
    assign ovf_y     = oy_reg[QB];
    assign side_out  = s_reg[QB];

endmodule

`default_nettype wire

>>> hw/rtl/warp_pp_back.sv
// ----------------------------------------------------------------------------
// Warp point projection back end
// Signs the quotient, applies the chroma offset, selects the model result,
// then clamps to 32 bits and forms the status in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_pp_back #(
    parameter int PIXEL_PREC_BITS = 6,
    parameter int QB              = 34
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  warp_pp_pkg::cfg_t                   cfg,
    input  logic                                in_valid,
    input  logic [QB-1:0]                       quo_x,
    input  logic [QB-1:0]                       quo_y,
    input  logic                                ovf_x,
    input  logic                                ovf_y,
    input  warp_pp_pkg::side_t                  side,
    output logic                                out_valid,
    output logic signed [warp_pp_pkg::ProjW-1:0] proj_x,
    output logic signed [warp_pp_pkg::ProjW-1:0] proj_y,
    output logic [1:0]                          status
);

    localparam int RW = warp_pp_pkg::RndW;
    localparam int QW = QB + 2;

    // signed quotient; when subsampled, chroma offset then a truncating half
    function automatic logic signed [RW-1:0] homo_coord(input logic [QB-1:0] q,
                                                        input logic ovf,
                                                        input logic neg,
                                                        input logic sub);
        logic signed [QW-1:0] qs;
        logic signed [QW-1:0] t;
        logic signed [QW-1:0] r;
        logic signed [RW-1:0] big;
        big = $signed(RW'(1)) <<< (QB + 1);
        qs  = $signed(QW'(q));
        if (neg)
            qs = -qs;
        t = qs - $signed(QW'(1) << (PIXEL_PREC_BITS - 1));
        r = sub ? ((t + $signed(QW'(t[QW-1]))) >>> 1) : qs;
        if (ovf)
            return neg ? -big : big;
        return RW'(r);
    endfunction

    // bound chosen by numerator sign when the denominator is zero
    function automatic logic signed [RW-1:0] zden_value(input logic pos, input logic neg);
        if (pos)
            return RW'(warp_pp_pkg::ProjMax);
        if (neg)
            return RW'(warp_pp_pkg::ProjMin);
        return '0;
    endfunction

    // ---------------- stage 1: coordinate select
    logic                 v1_reg, zden1_reg;
    logic signed [RW-1:0] cx1_reg, cy1_reg, cx_next, cy_next;
    logic                 homo;

    always_comb
    begin
        homo = (cfg.model == warp_pp_pkg::MODEL_HOMOGRAPHY);
        if (!homo)
        begin
            cx_next = $signed(side.rnd_x);
            cy_next = $signed(side.rnd_y);
        end
        else if (side.flags.zero_den)
        begin
            cx_next = zden_value(side.flags.nx_pos, side.flags.nx_neg);
            cy_next = zden_value(side.flags.ny_pos, side.flags.ny_neg);
        end
        else
        begin
            cx_next = homo_coord(quo_x, ovf_x, side.flags.neg_x, cfg.sub_x);
            cy_next = homo_coord(quo_y, ovf_y, side.flags.neg_y, cfg.sub_y);
        end
    end

    // ---------------- stage 2: clamp and status
    logic signed [warp_pp_pkg::ProjW-1:0] px_next, py_next;
    logic                                 sat_x, sat_y;
    logic [1:0]                           status_next;

    always_comb
    begin
        sat_x = (cx1_reg > RW'(warp_pp_pkg::ProjMax)) || (cx1_reg < RW'(warp_pp_pkg::ProjMin));
        sat_y = (cy1_reg > RW'(warp_pp_pkg::ProjMax)) || (cy1_reg < RW'(warp_pp_pkg::ProjMin));
        px_next = sat_x ? (cx1_reg[RW-1] ? warp_pp_pkg::ProjMin : warp_pp_pkg::ProjMax)
                        : cx1_reg[warp_pp_pkg::ProjW-1:0];
        py_next = sat_y ? (cy1_reg[RW-1] ? warp_pp_pkg::ProjMin : warp_pp_pkg::ProjMax)
                        : cy1_reg[warp_pp_pkg::ProjW-1:0];
        if (zden1_reg)
            status_next = warp_pp_pkg::STATUS_ZERO_DEN;
        else if (sat_x || sat_y)
            status_next = warp_pp_pkg::STATUS_SAT;
        else
            status_next = warp_pp_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx1_reg   <= cx_next;
            cy1_reg   <= cy_next;
            zden1_reg <= homo && side.flags.zero_den;
            proj_x    <= px_next;
            proj_y    <= py_next;
            status    <= status_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/warp_point_projection_top.sv
// ----------------------------------------------------------------------------
// Warp point projection top level
// Projects integer points through a translation, rotate-zoom, affine or
// homography model into sub-pixel units, with clamping and status.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | point_x, point_y
//  output   | out_valid / out_ready| proj_x, proj_y, status
//  config   | cfg_we               | cfg_index, cfg_data
//
//  One point per cycle while the output is not stalled; the pipeline has 5 front
//  stages, QuotBits+1 divider stages and 2 back stages, most of them in the
//  bit-per-stage homography divider. All stages move together: a stalled output
//  holds every stage, no bubble is lost or repeated. Reset clears valid bits and
//  all model registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "warp_point_projection_top_assert.svh"

module warp_point_projection_top #(
    parameter int MODEL_PREC_BITS = 8,
    parameter int PIXEL_PREC_BITS = 6,
    parameter int HOMO_PREC_BITS  = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [warp_pp_pkg::PointW-1:0] point_x,
    input  logic signed [warp_pp_pkg::PointW-1:0] point_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [warp_pp_pkg::ProjW-1:0]  proj_x,
    output logic signed [warp_pp_pkg::ProjW-1:0]  proj_y,
    output logic [1:0]                            status,
    input  logic                                  cfg_we,
    input  logic [warp_pp_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [warp_pp_pkg::CfgDataW-1:0]      cfg_data
);

    localparam int Hs     = PIXEL_PREC_BITS + HOMO_PREC_BITS - MODEL_PREC_BITS;
    localparam int HsPos  = (Hs > 0) ? Hs : 0;
    localparam int NumW   = warp_pp_pkg::SumW + HsPos + 1;
    localparam int SideW  = $bits(warp_pp_pkg::side_t);
    localparam int Qb     = warp_pp_pkg::QuotBits;

    // model registers
    warp_pp_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_index)
            warp_pp_pkg::CFG_MODEL_TYPE:  cfg_next.model = warp_pp_pkg::model_t'(cfg_data[1:0]);
            warp_pp_pkg::CFG_SUBSAMPLE_X: cfg_next.sub_x = cfg_data[0];
            warp_pp_pkg::CFG_SUBSAMPLE_Y: cfg_next.sub_y = cfg_data[0];
            warp_pp_pkg::CFG_COEF_A:
            begin
                cfg_next.coef[0] = cfg_data[31:0];
                cfg_next.coef[1] = cfg_data[63:32];
            end
            warp_pp_pkg::CFG_COEF_B:
            begin
                cfg_next.coef[2] = cfg_data[31:0];
                cfg_next.coef[3] = cfg_data[63:32];
            end
            warp_pp_pkg::CFG_COEF_C:
            begin
                cfg_next.coef[4] = cfg_data[31:0];
                cfg_next.coef[5] = cfg_data[63:32];
            end
            warp_pp_pkg::CFG_COEF_D:
            begin
                cfg_next.coef[6] = cfg_data[31:0];
                cfg_next.coef[7] = cfg_data[63:32];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
            cfg_reg <= cfg_next;
    end

    // pipeline advance: output register free or being taken
    logic pipe_en;

    assign pipe_en  = !out_valid || out_ready;
    assign in_ready = pipe_en;

    // front end
    logic                          div_in_valid;
    logic [NumW-1:0]               nabs_x, nabs_y;
    logic [warp_pp_pkg::SumW-1:0]  den;
    warp_pp_pkg::side_t            front_side;

    warp_pp_front #(
        .MODEL_PREC_BITS (MODEL_PREC_BITS),
        .PIXEL_PREC_BITS (PIXEL_PREC_BITS),
        .HOMO_PREC_BITS  (HOMO_PREC_BITS),
        .NUM_W           (NumW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (div_in_valid),
        .nabs_x    (nabs_x),
        .nabs_y    (nabs_y),
        .den       (den),
        .side      (front_side)
    );

    // divider
    logic              back_in_valid;
    logic [Qb-1:0]     quo_x, quo_y;
    logic              ovf_x, ovf_y;
    logic [SideW-1:0]  div_side;

    warp_pp_div #(
        .NUM_W  (NumW),
        .DEN_W  (warp_pp_pkg::SumW),
        .QB     (Qb),
        .SIDE_W (SideW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (div_in_valid),
        .nabs_x    (nabs_x),
        .nabs_y    (nabs_y),
        .den       (den),
        .side_in   (front_side),
        .out_valid (back_in_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .ovf_x     (ovf_x),
        .ovf_y     (ovf_y),
        .side_out  (div_side)
    );

    // back end and output register
    warp_pp_back #(
        .PIXEL_PREC_BITS (PIXEL_PREC_BITS),
        .QB              (Qb)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (back_in_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .ovf_x     (ovf_x),
        .ovf_y     (ovf_y),
        .side      (warp_pp_pkg::side_t'(div_side)),
        .out_valid (out_valid),
        .proj_x    (proj_x),
        .proj_y    (proj_y),
        .status    (status)
    );

    // checks
    `WPP_ASSERT_IMP(a_zden_bounds,
        out_valid && (status == warp_pp_pkg::STATUS_ZERO_DEN),
        (proj_x == warp_pp_pkg::ProjMax || proj_x == warp_pp_pkg::ProjMin || proj_x == '0) &&
        (proj_y == warp_pp_pkg::ProjMax || proj_y == warp_pp_pkg::ProjMin || proj_y == '0))
    `WPP_ASSERT_IMP(a_sat_at_bound,
        out_valid && (status == warp_pp_pkg::STATUS_SAT),
        proj_x == warp_pp_pkg::ProjMax || proj_x == warp_pp_pkg::ProjMin ||
        proj_y == warp_pp_pkg::ProjMax || proj_y == warp_pp_pkg::ProjMin)
    `WPP_ASSERT_IMP(a_zden_homo_only,
        out_valid && (cfg_reg.model != warp_pp_pkg::MODEL_HOMOGRAPHY),
        status != warp_pp_pkg::STATUS_ZERO_DEN)
    `WPP_ASSERT_NXT(a_stall_keeps_item,
        !pipe_en && div_in_valid,
        div_in_valid)

endmodule

`default_nettype wire
